// ===== design/ampl_pkg.sv =====
// Shared types and constants for the audio mixer with peak limiting.
// No dependencies; ampl_ctrl, ampl_datapath and the top module import this package.
package ampl_pkg;

    // Field widths
    localparam int SAMPLE_W   = 16;   // Q1.15 input sample
    localparam int MIX_W      = 24;   // Q9.15 mix buffer entry
    localparam int FRAC_W     = 15;
    localparam int OC_W       = 4;    // output channel register
    localparam int Q_W        = 16;   // scaled quotient, at most 32768
    localparam int DIV_CW     = 4;    // divider step counter
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 4;

    // Function codes
    localparam logic [1:0] FUNC_ADD    = 2'd0;
    localparam logic [1:0] FUNC_FINISH = 2'd1;
    localparam logic [1:0] FUNC_READ   = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_AUTO_LIMIT   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_CHANNELS = 1'd1;

    localparam logic [OC_W-1:0] OC_RESET = 4'd2;

    // Fixed point constants
    localparam logic [MIX_W-1:0]        ONE_Q15 = 24'd32768;
    localparam logic signed [MIX_W-1:0] SAT_HI  = 24'sh7FFFFF;
    localparam logic signed [MIX_W-1:0] SAT_LO  = 24'sh800000;

    typedef struct packed {
        logic [1:0]                 func;
        logic [2:0]                 source;
        logic [2:0]                 channel;
        logic signed [SAMPLE_W-1:0] sample;
        logic                       frame_end;
    } ampl_item_t;

    typedef struct packed {
        logic signed [MIX_W-1:0] mixed_sample;
        logic                    last_of_block;
        logic                    empty_res;
    } ampl_result_t;

    // Controller to datapath
    typedef struct packed {
        logic load_item;
        logic clear_step;
        logic add_addr;
        logic add_read;
        logic add_write;
        logic scan_step;
        logic fin_total;
        logic fin_mul;
        logic walk_step;
        logic rd_total;
        logic rd_check;
        logic div_step;
        logic out_load;
    } ampl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic scan_last;
        logic walk_last;
        logic rd_empty;
        logic need_div;
        logic div_last;
        logic out_busy;
    } ampl_status_t;

endpackage

// ===== design/ampl_stream_if.sv =====
// Valid/ready stream channel carrying one word of payload type T.
// No dependencies; the payload type is supplied by the instantiating scope.
interface ampl_stream_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== design/ampl_ctrl.sv =====
// Sequencer for the mixer: clear pass, add, finish and read flows.
// Depends on ampl_pkg for the command and status structs and function codes.
module ampl_ctrl
    import ampl_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    input  logic [1:0]   in_func,
    output logic         in_ready,
    input  ampl_status_t status,
    output ampl_cmd_t    cmd
);

    typedef enum logic [3:0] {
        CLEAR,
        IDLE,
        ADD_ADDR,
        ADD_RD,
        ADD_WR,
        FIN_SCAN,
        FIN_TOTAL,
        FIN_MUL,
        FIN_WALK,
        FIN_DRAIN,
        RD_TOTAL,
        RD_CHECK,
        RD_DIV,
        RD_OUT
    } state_t;

    state_t state_reg, state_next;

    assign in_ready = (state_reg == IDLE);

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (status.walk_last)
                    state_next = IDLE;
            end
            IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    unique case (in_func)
                        FUNC_ADD:    state_next = ADD_ADDR;
                        FUNC_FINISH: state_next = FIN_SCAN;
                        FUNC_READ:   state_next = RD_TOTAL;
                        default:     state_next = IDLE;
                    endcase
                end
            end
            ADD_ADDR:
            begin
                cmd.add_addr = 1'b1;
                state_next   = ADD_RD;
            end
            ADD_RD:
            begin
                cmd.add_read = 1'b1;
                state_next   = ADD_WR;
            end
            ADD_WR:
            begin
                cmd.add_write = 1'b1;
                state_next    = IDLE;
            end
            FIN_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (status.scan_last)
                    state_next = FIN_TOTAL;
            end
            FIN_TOTAL:
            begin
                cmd.fin_total = 1'b1;
                state_next    = FIN_MUL;
            end
            FIN_MUL:
            begin
                cmd.fin_mul = 1'b1;
                state_next  = FIN_WALK;
            end
            FIN_WALK:
            begin
                cmd.walk_step = 1'b1;
                if (status.walk_last)
                    state_next = FIN_DRAIN;
            end
            FIN_DRAIN:
            begin
                // last peak compare lands this cycle
                state_next = IDLE;
            end
            RD_TOTAL:
            begin
                cmd.rd_total = 1'b1;
                state_next   = RD_CHECK;
            end
            RD_CHECK:
            begin
                cmd.rd_check = 1'b1;
                if (!status.rd_empty && status.need_div)
                    state_next = RD_DIV;
                else
                    state_next = RD_OUT;
            end
            RD_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                    state_next = RD_OUT;
            end
            RD_OUT:
            begin
                if (!status.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = IDLE;
                end
            end
            default: state_next = IDLE;
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= CLEAR;
        else
            state_reg <= state_next;
    end

endmodule

// ===== design/ampl_datapath.sv =====
// Mixer datapath: config registers, source pointers, mix buffer memory,
// peak tracking, serial divider for limiting and the output word register.
// Depends on ampl_pkg for types, widths and constants.
module ampl_datapath
    import ampl_pkg::*;
#(
    parameter int MAX_FRAMES   = 1024,
    parameter int MAX_CHANNELS = 8,
    parameter int MAX_SOURCES  = 8
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  ampl_item_t            in_data,
    input  logic                  res_ready,
    output logic                  res_valid,
    output ampl_result_t          res_data,
    input  ampl_cmd_t             cmd,
    output ampl_status_t          status
);

    localparam int BUF_DEPTH = MAX_FRAMES * MAX_CHANNELS;
    localparam int AW        = $clog2(BUF_DEPTH);
    localparam int TW        = $clog2(BUF_DEPTH + 1);
    localparam int FP_W      = $clog2(MAX_FRAMES + 1);
    localparam int SRC_W     = (MAX_SOURCES > 1) ? $clog2(MAX_SOURCES) : 1;
    localparam int PW        = FP_W + OC_W;
    localparam int NUM_W     = MIX_W + FRAC_W;

    function automatic logic [MIX_W-1:0] abs_mix(input logic signed [MIX_W-1:0] v);
        abs_mix = v[MIX_W-1] ? (~v + 1'b1) : v;
    endfunction

    // Configuration
    logic            auto_limit_reg;
    logic [OC_W-1:0] out_ch_reg;
    logic [OC_W-1:0] oc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            auto_limit_reg <= 1'b0;
            out_ch_reg     <= OC_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_AUTO_LIMIT:   auto_limit_reg <= cfg_data[0];
                CFG_OUT_CHANNELS: out_ch_reg     <= cfg_data[OC_W-1:0];
                default:          ;
            endcase
        end
    end

    // Effective channel count
    always_comb
    begin
        if (out_ch_reg == '0)
            oc = OC_W'(1);
        else if (out_ch_reg > OC_W'(MAX_CHANNELS))
            oc = OC_W'(MAX_CHANNELS);
        else
            oc = out_ch_reg;
    end

    // Item capture
    ampl_item_t item_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
            item_reg <= in_data;
    end

    // Source state
    logic [FP_W-1:0]  fp_reg     [MAX_SOURCES];
    logic             active_reg [MAX_SOURCES];
    logic [SRC_W-1:0] src_idx;
    logic             src_ok;
    logic [FP_W-1:0]  fp_sel;
    logic             fp_room;
    logic             ch_ok;
    logic [PW-1:0]    addr_calc;

    assign src_idx   = SRC_W'(item_reg.source);
    assign src_ok    = (int'(item_reg.source) < MAX_SOURCES);
    assign fp_sel    = fp_reg[src_idx];
    assign fp_room   = (fp_sel < FP_W'(MAX_FRAMES));
    assign ch_ok     = ({1'b0, item_reg.channel} < oc);
    assign addr_calc = PW'(fp_sel) * PW'(oc) + PW'(item_reg.channel);

    // Finish scan
    logic [SRC_W-1:0] scan_cnt_reg;
    logic [FP_W-1:0]  minp_reg;
    logic             any_reg;
    logic [FP_W-1:0]  block_len_reg;
    logic [TW-1:0]    total_reg;
    logic [PW-1:0]    total_calc;

    assign total_calc = PW'(block_len_reg) * PW'(oc);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_SOURCES; i++)
            begin
                fp_reg[i]     <= '0;
                active_reg[i] <= 1'b0;
            end
            scan_cnt_reg  <= '0;
            minp_reg      <= FP_W'(MAX_FRAMES);
            any_reg       <= 1'b0;
            block_len_reg <= '0;
            total_reg     <= '0;
        end
        else
        begin
            if (cmd.load_item)
            begin
                scan_cnt_reg <= '0;
                minp_reg     <= FP_W'(MAX_FRAMES);
                any_reg      <= 1'b0;
            end
            // pointer advance on add
            if (cmd.add_addr && src_ok)
            begin
                active_reg[src_idx] <= 1'b1;
                if (fp_room && item_reg.frame_end)
                    fp_reg[src_idx] <= fp_sel + 1'b1;
            end
            // one source per cycle into the running minimum
            if (cmd.scan_step)
            begin
                scan_cnt_reg <= scan_cnt_reg + 1'b1;
                if (active_reg[scan_cnt_reg])
                begin
                    any_reg <= 1'b1;
                    if (fp_reg[scan_cnt_reg] < minp_reg)
                        minp_reg <= fp_reg[scan_cnt_reg];
                end
            end
            if (cmd.fin_total)
            begin
                block_len_reg <= any_reg ? minp_reg : '0;
                for (int i = 0; i < MAX_SOURCES; i++)
                begin
                    fp_reg[i]     <= '0;
                    active_reg[i] <= 1'b0;
                end
            end
            if (cmd.fin_mul || cmd.rd_total)
                total_reg <= TW'(total_calc);
        end
    end

    assign status.scan_last = (scan_cnt_reg == SRC_W'(MAX_SOURCES - 1));

    // Buffer walk counter, peak and read pointer
    logic [AW-1:0]    walk_cnt_reg;
    logic             walk_in_blk;
    logic             walk_last;
    logic [MIX_W-1:0] peak_reg;
    logic             pk_pend_reg;
    logic [TW-1:0]    rp_reg;
    logic [TW-1:0]    rp_inc;
    logic             rd_empty;
    logic signed [MIX_W-1:0] rdata_reg;
    logic [MIX_W-1:0] rd_abs;

    assign walk_in_blk = (TW'(walk_cnt_reg) < total_reg);
    assign walk_last   = (walk_cnt_reg == AW'(BUF_DEPTH - 1));
    assign rp_inc      = rp_reg + 1'b1;
    assign rd_empty    = (rp_reg >= total_reg);
    assign rd_abs      = abs_mix(rdata_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            walk_cnt_reg <= '0;
            peak_reg     <= '0;
            pk_pend_reg  <= 1'b0;
            rp_reg       <= '0;
        end
        else
        begin
            if (cmd.clear_step || cmd.walk_step)
                walk_cnt_reg <= walk_last ? '0 : walk_cnt_reg + 1'b1;
            pk_pend_reg <= cmd.walk_step && walk_in_blk && auto_limit_reg;
            if (cmd.fin_total)
                peak_reg <= '0;
            else if (pk_pend_reg && (rd_abs > peak_reg))
                peak_reg <= rd_abs;
            if (cmd.fin_mul)
                rp_reg <= '0;
            else if (cmd.rd_check && !rd_empty)
                rp_reg <= rp_inc;
        end
    end

    assign status.walk_last = walk_last;
    assign status.rd_empty  = rd_empty;
    assign status.need_div  = (peak_reg > ONE_Q15);

    // Add operand register
    logic [AW-1:0] addr_reg;
    logic          wr_ok_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.add_addr)
        begin
            addr_reg  <= addr_calc[AW-1:0];
            wr_ok_reg <= src_ok && fp_room && ch_ok;
        end
    end

    // Saturating accumulate
    logic signed [MIX_W:0]   sum;
    logic signed [MIX_W-1:0] sum_sat;

    assign sum     = {rdata_reg[MIX_W-1], rdata_reg}
                   + {{(MIX_W + 1 - SAMPLE_W){item_reg.sample[SAMPLE_W-1]}}, item_reg.sample};
    assign sum_sat = (sum[MIX_W] != sum[MIX_W-1]) ? (sum[MIX_W] ? SAT_LO : SAT_HI)
                                                   : sum[MIX_W-1:0];

    // Mix buffer port selection
    logic                    mem_we;
    logic [AW-1:0]           mem_waddr;
    logic signed [MIX_W-1:0] mem_wdata;
    logic                    mem_re;
    logic [AW-1:0]           mem_raddr;

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = walk_cnt_reg;
        mem_wdata = '0;
        mem_re    = 1'b0;
        mem_raddr = walk_cnt_reg;
        if (cmd.clear_step)
            mem_we = 1'b1;
        if (cmd.walk_step)
        begin
            mem_re = 1'b1;
            mem_we = !walk_in_blk;
        end
        if (cmd.add_read)
        begin
            mem_re    = 1'b1;
            mem_raddr = addr_reg;
        end
        if (cmd.add_write)
        begin
            mem_we    = wr_ok_reg;
            mem_waddr = addr_reg;
            mem_wdata = sum_sat;
        end
        if (cmd.rd_total)
        begin
            mem_re    = 1'b1;
            mem_raddr = rp_reg[AW-1:0];
        end
        if (cmd.rd_check)
        begin
            mem_we    = !rd_empty;
            mem_waddr = rp_reg[AW-1:0];
        end
    end

    // Mix buffer
    logic signed [MIX_W-1:0] mem [BUF_DEPTH];

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            rdata_reg <= mem[mem_raddr];
    end

    // Restoring divider: (|v| * 2^15 + peak/2) / peak, one quotient bit a cycle
    logic [NUM_W-1:0]  num;
    logic [MIX_W-1:0]  rem_reg;
    logic [Q_W-1:0]    num_lo_reg;
    logic [Q_W-1:0]    quo_reg;
    logic              neg_reg;
    logic [DIV_CW-1:0] div_cnt_reg;
    logic [MIX_W:0]    trial;
    logic              ge;
    logic [MIX_W:0]    trial_sub;
    logic [Q_W-1:0]    quo_fin;
    logic [MIX_W-1:0]  quo_ext;

    assign num       = {rd_abs, {FRAC_W{1'b0}}} + NUM_W'(peak_reg[MIX_W-1:1]);
    assign trial     = {rem_reg, num_lo_reg[Q_W-1]};
    assign ge        = (trial >= {1'b0, peak_reg});
    assign trial_sub = trial - {1'b0, peak_reg};
    assign quo_fin   = {quo_reg[Q_W-2:0], ge};
    assign quo_ext   = MIX_W'(quo_fin);

    assign status.div_last = (div_cnt_reg == DIV_CW'(Q_W - 1));

    // Result staging
    logic signed [MIX_W-1:0] res_val_reg;
    logic                    res_last_reg;
    logic                    res_empty_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.rd_check)
        begin
            rem_reg     <= num[NUM_W-1:Q_W];
            num_lo_reg  <= num[Q_W-1:0];
            neg_reg     <= rdata_reg[MIX_W-1];
            quo_reg     <= '0;
            div_cnt_reg <= '0;
            if (rd_empty)
            begin
                res_val_reg   <= '0;
                res_last_reg  <= 1'b0;
                res_empty_reg <= 1'b1;
            end
            else
            begin
                res_val_reg   <= rdata_reg;
                res_last_reg  <= (rp_inc == total_reg);
                res_empty_reg <= 1'b0;
            end
        end
        if (cmd.div_step)
        begin
            rem_reg     <= ge ? trial_sub[MIX_W-1:0] : trial[MIX_W-1:0];
            num_lo_reg  <= {num_lo_reg[Q_W-2:0], 1'b0};
            quo_reg     <= quo_fin;
            div_cnt_reg <= div_cnt_reg + 1'b1;
            if (status.div_last)
                res_val_reg <= neg_reg ? -quo_ext : quo_ext;
        end
    end

    // Output word register
    logic         out_valid_reg;
    ampl_result_t out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (res_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_data_reg.mixed_sample  <= res_val_reg;
            out_data_reg.last_of_block <= res_last_reg;
            out_data_reg.empty_res     <= res_empty_reg;
        end
    end

    assign status.out_busy = out_valid_reg && !res_ready;
    assign res_valid       = out_valid_reg;
    assign res_data        = out_data_reg;

endmodule

// ===== design/audio_mixer_peak_limit_unit.sv =====
// Audio mixer with peak limiting. Add: address, read and write states. Finish: a
// source scan, block total and a walk over all MAX_FRAMES*MAX_CHANNELS buffer entries.
// Read: total, check, the serial divider when the block is scaled, and the output word.
// One word in flight; a result waiting in the output register does not block adds.
// After rst_n the mix buffer, MAX_FRAMES*MAX_CHANNELS entries or 8192 by default, is
// zeroed with item.ready low; configuration writes are taken throughout.
module audio_mixer_peak_limit_unit
    import ampl_pkg::*;
#(
    parameter int MAX_FRAMES   = 1024,
    parameter int MAX_CHANNELS = 8,
    parameter int MAX_SOURCES  = 8
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    ampl_stream_if.sink           item,
    ampl_stream_if.source         result
);

    ampl_cmd_t    cmd;
    ampl_status_t status;
    ampl_item_t   item_word;
    ampl_result_t result_word;

    assign item_word   = item.data;
    assign result.data = result_word;

    // Sequencer
    ampl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (item.valid),
        .in_func  (item_word.func),
        .in_ready (item.ready),
        .status   (status),
        .cmd      (cmd)
    );

    // Datapath
    ampl_datapath #(
        .MAX_FRAMES   (MAX_FRAMES),
        .MAX_CHANNELS (MAX_CHANNELS),
        .MAX_SOURCES  (MAX_SOURCES)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (item_word),
        .res_ready (result.ready),
        .res_valid (result.valid),
        .res_data  (result_word),
        .cmd       (cmd),
        .status    (status)
    );

endmodule
